>>> hw/rtl/i2c_master_byte_engine_core_defines.svh
// Assertion macros used by the I2C master byte engine core.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/i2cm_pkg.sv
// Types and constants of the I2C master byte engine.
package i2cm_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int DELAY_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;

    localparam logic [DELAY_W-1:0] DELAY_RESET     = 16'd160;
    localparam logic [BYTE_W-1:0]  POLL_LIMIT_RESET = 8'd255;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE  = 4'd8;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_DELAY_CYCLES   = 1'b0,
        REG_ACK_POLL_LIMIT = 1'b1
    } reg_idx_t;

    // Running operation; codes match the command field
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Line sequence steps
    typedef enum logic [4:0] {
        PH_IDLE           = 5'd0,
        PH_S_SDA_LOW      = 5'd1,
        PH_S_SCL_LOW      = 5'd2,
        PH_T_SCL_HIGH     = 5'd3,
        PH_T_SDA_HIGH     = 5'd4,
        PH_W_SCL_HIGH     = 5'd5,
        PH_W_SCL_LOW      = 5'd6,
        PH_W_ACK_SCL_HIGH = 5'd7,
        PH_W_POLL         = 5'd8,
        PH_W_SCL_END      = 5'd9,
        PH_R_SCL_HIGH     = 5'd10,
        PH_R_SAMPLE       = 5'd11,
        PH_R_ACK_DRIVE    = 5'd12,
        PH_R_ACK_HIGH     = 5'd13,
        PH_R_ACK_LOW      = 5'd14,
        PH_R_SDA_LOW      = 5'd15,
        PH_FINISH         = 5'd16
    } phase_t;

    // Sequencer state
    typedef struct packed {
        op_t                  op;
        phase_t               phase;
        logic [BIT_CNT_W-1:0] bit_index;
        logic [BYTE_W-1:0]    shifter;
        logic [DELAY_W-1:0]   delay_cnt;
        logic [BYTE_W-1:0]    poll_cnt;
        logic [BYTE_W-1:0]    last_read;
        logic [BYTE_W-1:0]    last_ack;
        logic                 scl_lvl;
        logic                 scl_en;
        logic                 sda_lvl;
        logic                 sda_en;
    } seq_state_t;

    // One result item, first field in the highest bits
    typedef struct packed {
        logic [BYTE_W-1:0] ack_count;
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_enable;
        logic              sda_level;
        logic              scl_enable;
        logic              scl_level;
    } result_t;

endpackage

>>> hw/rtl/i2cm_step.sv
// Next-state and result logic for one tick of the I2C line sequencer.
module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t          state,
    input  logic [DELAY_W-1:0]  delay_cycles,
    input  logic [BYTE_W-1:0]   ack_poll_limit,
    input  logic [2:0]          command,
    input  logic [BYTE_W-1:0]   write_byte,
    input  logic                nack,
    input  logic                sda_in,
    output seq_state_t          state_next,
    output result_t             result
);

    logic [DELAY_W-1:0]   dly_eff;
    logic [DELAY_W-1:0]   dly_reload;
    logic [BYTE_W-1:0]    poll_start;
    logic [BYTE_W-1:0]    shift_next;
    logic [BYTE_W-1:0]    poll_dec;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic                 done;

    // Zero delay or zero poll limit behave as one
    assign dly_eff    = (delay_cycles == '0) ? DELAY_W'(1) : delay_cycles;
    assign dly_reload = dly_eff - DELAY_W'(1);
    assign poll_start = (ack_poll_limit == '0) ? BYTE_W'(1) : ack_poll_limit;
    assign poll_dec   = state.poll_cnt - BYTE_W'(1);
    assign bit_inc    = state.bit_index + BIT_CNT_W'(1);

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        shift_next = state.shifter;

        if (state.op == OP_IDLE)
        begin
            // take a command
            case (command)
                OP_START:
                begin
                    state_next.op        = OP_START;
                    state_next.bit_index = '0;
                    state_next.scl_lvl   = 1'b1;
                    state_next.sda_lvl   = 1'b1;
                    state_next.sda_en    = 1'b1;
                    state_next.scl_en    = 1'b1;
                    state_next.delay_cnt = dly_reload;
                    state_next.phase     = PH_S_SDA_LOW;
                end
                OP_STOP:
                begin
                    state_next.op        = OP_STOP;
                    state_next.bit_index = '0;
                    state_next.sda_en    = 1'b1;
                    state_next.sda_lvl   = 1'b0;
                    state_next.delay_cnt = dly_reload;
                    state_next.phase     = PH_T_SCL_HIGH;
                end
                OP_WRITE:
                begin
                    state_next.op        = OP_WRITE;
                    state_next.bit_index = '0;
                    state_next.shifter   = write_byte;
                    state_next.sda_en    = 1'b1;
                    state_next.sda_lvl   = write_byte[BYTE_W-1];
                    state_next.delay_cnt = dly_reload;
                    state_next.phase     = PH_W_SCL_HIGH;
                end
                OP_READ:
                begin
                    state_next.op        = OP_READ;
                    state_next.bit_index = '0;
                    state_next.shifter   = '0;
                    state_next.sda_en    = 1'b0;
                    state_next.sda_lvl   = 1'b1;
                    state_next.delay_cnt = dly_reload;
                    state_next.phase     = PH_R_SCL_HIGH;
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
        else if (state.delay_cnt != '0)
        begin
            // line delay running
            state_next.delay_cnt = state.delay_cnt - DELAY_W'(1);
        end
        else
        begin
            // one line step; each step restarts the delay
            state_next.delay_cnt = dly_reload;
            case (state.phase)
                PH_S_SDA_LOW:
                begin
                    state_next.sda_lvl = 1'b0;
                    state_next.phase   = PH_S_SCL_LOW;
                end
                PH_S_SCL_LOW, PH_W_SCL_END:
                begin
                    state_next.scl_lvl = 1'b0;
                    state_next.phase   = PH_FINISH;
                end
                PH_R_ACK_LOW:
                begin
                    state_next.scl_lvl = 1'b0;
                    state_next.phase   = PH_R_SDA_LOW;
                end
                PH_T_SCL_HIGH:
                begin
                    state_next.scl_lvl = 1'b1;
                    state_next.phase   = PH_T_SDA_HIGH;
                end
                PH_T_SDA_HIGH:
                begin
                    state_next.sda_lvl = 1'b1;
                    state_next.phase   = PH_FINISH;
                end
                PH_W_SCL_HIGH:
                begin
                    state_next.scl_lvl = 1'b1;
                    state_next.phase   = PH_W_SCL_LOW;
                end
                PH_W_SCL_LOW:
                begin
                    // next bit goes out with the falling clock
                    shift_next           = {state.shifter[BYTE_W-2:0], 1'b0};
                    state_next.shifter   = shift_next;
                    state_next.bit_index = bit_inc;
                    state_next.scl_lvl   = 1'b0;
                    if (bit_inc < BITS_PER_BYTE)
                    begin
                        state_next.sda_en  = 1'b1;
                        state_next.sda_lvl = shift_next[BYTE_W-1];
                        state_next.phase   = PH_W_SCL_HIGH;
                    end
                    else
                    begin
                        state_next.sda_en  = 1'b0;
                        state_next.sda_lvl = 1'b1;
                        state_next.phase   = PH_W_ACK_SCL_HIGH;
                    end
                end
                PH_W_ACK_SCL_HIGH:
                begin
                    state_next.scl_lvl  = 1'b1;
                    state_next.poll_cnt = poll_start;
                    state_next.phase    = PH_W_POLL;
                end
                PH_W_POLL:
                begin
                    if (!sda_in)
                    begin
                        // acknowledge seen: keep the remaining count
                        state_next.last_ack = state.poll_cnt;
                        state_next.scl_lvl  = 1'b0;
                        state_next.phase    = PH_FINISH;
                    end
                    else
                    begin
                        state_next.poll_cnt = poll_dec;
                        if (poll_dec == '0)
                        begin
                            state_next.last_ack = '0;
                            state_next.phase    = PH_W_SCL_END;
                        end
                        else
                        begin
                            state_next.phase = PH_W_POLL;
                        end
                    end
                end
                PH_R_SCL_HIGH:
                begin
                    state_next.scl_lvl = 1'b1;
                    state_next.phase   = PH_R_SAMPLE;
                end
                PH_R_SAMPLE:
                begin
                    shift_next           = {state.shifter[BYTE_W-2:0], sda_in};
                    state_next.shifter   = shift_next;
                    state_next.scl_lvl   = 1'b0;
                    state_next.bit_index = bit_inc;
                    if (bit_inc < BITS_PER_BYTE)
                    begin
                        state_next.phase = PH_R_SCL_HIGH;
                    end
                    else
                    begin
                        state_next.last_read = shift_next;
                        state_next.phase     = PH_R_ACK_DRIVE;
                    end
                end
                PH_R_ACK_DRIVE:
                begin
                    state_next.sda_en  = 1'b1;
                    state_next.sda_lvl = nack;
                    state_next.phase   = PH_R_ACK_HIGH;
                end
                PH_R_ACK_HIGH:
                begin
                    state_next.scl_lvl = 1'b1;
                    state_next.phase   = PH_R_ACK_LOW;
                end
                PH_R_SDA_LOW:
                begin
                    state_next.sda_lvl = 1'b0;
                    state_next.phase   = PH_FINISH;
                end
                default:
                begin
                    // finish tick: back to idle
                    state_next.op        = OP_IDLE;
                    state_next.phase     = PH_IDLE;
                    state_next.delay_cnt = '0;
                    done                 = 1'b1;
                end
            endcase
        end
    end

    // Result reflects the state after this tick
    always_comb
    begin
        result.scl_level  = state_next.scl_lvl;
        result.scl_enable = state_next.scl_en;
        result.sda_level  = state_next.sda_lvl;
        result.sda_enable = state_next.sda_en;
        result.busy_res   = (state_next.op != OP_IDLE);
        result.done_res   = done;
        result.read_byte  = state_next.last_read;
        result.ack_count  = state_next.last_ack;
    end

endmodule

>>> hw/rtl/i2c_master_byte_engine_core.sv
// I2C master byte engine: line sequencer with stream ports and output skid buffer.
//
// Each input transaction is one tick of the I2C line sequencer and yields exactly
// one output transaction with the pin drives, busy/done flags, last read byte and
// acknowledge count after that tick. One transaction is taken per clock cycle
// while the skid entry is empty; state feeds back through next-state logic and
// the result is registered into a two-entry output buffer whose skid entry lets
// input keep flowing for one extra transaction while the output is stalled.
// Line steps of start, stop, write and read sequences are max(delay_cycles, 1)
// ticks apart; commands are taken only while idle, and not on the finish tick.
`include "i2c_master_byte_engine_core_defines.svh"

module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_index,
    input  logic [DELAY_W-1:0]     cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] command, [10:3] write_byte, [11] nack, [12] sda_in, [15:13] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] scl_level, [1] scl_enable, [2] sda_level, [3] sda_enable, [4] busy_res,
    // [5] done_res, [13:6] read_byte, [21:14] ack_count, [23:22] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int RES_W = $bits(result_t);

    logic [DELAY_W-1:0] delay_cycles_reg;
    logic [BYTE_W-1:0]  ack_poll_limit_reg;
    seq_state_t         state_reg;
    seq_state_t         state_next;
    result_t            step_res;
    result_t            out_reg;
    result_t            skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               in_xfer;
    logic               out_xfer;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cycles_reg   <= DELAY_RESET;
            ack_poll_limit_reg <= POLL_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DELAY_CYCLES:   delay_cycles_reg   <= cfg_wdata;
                REG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_wdata[BYTE_W-1:0];
                default:            delay_cycles_reg   <= delay_cycles_reg;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_xfer = out_valid_reg && m_tready;
    assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_reg};

    // Tick logic
    i2cm_step u_step (
        .state          (state_reg),
        .delay_cycles   (delay_cycles_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .command        (s_tdata[2:0]),
        .write_byte     (s_tdata[10:3]),
        .nack           (s_tdata[11]),
        .sda_in         (s_tdata[12]),
        .state_next     (state_next),
        .result         (step_res)
    );

    // Sequencer state advances once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op        <= OP_IDLE;
            state_reg.phase     <= PH_IDLE;
            state_reg.bit_index <= '0;
            state_reg.shifter   <= '0;
            state_reg.delay_cnt <= '0;
            state_reg.poll_cnt  <= '0;
            state_reg.last_read <= '0;
            state_reg.last_ack  <= '0;
            state_reg.scl_lvl   <= 1'b1;
            state_reg.scl_en    <= 1'b0;
            state_reg.sda_lvl   <= 1'b1;
            state_reg.sda_en    <= 1'b0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!in_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the output buffer
    always_ff @(posedge clk)
    begin
        if (out_xfer && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (in_xfer && (out_xfer || !out_valid_reg))
        begin
            out_reg <= step_res;
        end

        if (in_xfer && out_valid_reg && !out_xfer)
        begin
            skid_reg <= step_res;
        end
    end

    // Checks
    `I2CM_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg,
        "skid entry valid while output register empty")
    `I2CM_ASSERT_IMP(a_idle_clean, state_reg.op == OP_IDLE,
        state_reg.phase == PH_IDLE && state_reg.delay_cnt == '0,
        "idle sequencer with a pending step or delay")
    `I2CM_ASSERT_IMP(a_bit_bound, 1'b1, state_reg.bit_index <= BITS_PER_BYTE,
        "bit counter past one byte")
    `I2CM_ASSERT_IMP(a_done_not_busy, step_res.done_res, !step_res.busy_res,
        "done raised while still busy")
    `I2CM_ASSERT_NXT(a_stall_to_skid, in_xfer && out_valid_reg && !m_tready,
        skid_valid_reg, "stalled transaction not held in skid entry")

endmodule

>>> test/i2c_master_byte_engine_core_tb.sv
// Self-checking testbench for the I2C master byte engine line sequencer.
`timescale 1ns / 100ps

module i2c_master_byte_engine_core_tb;
    import i2cm_pkg::*;

    localparam int          TIMEOUT_NS     = 400_000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [2:0]  CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  CMD_RSVD_LAST  = 3'd7;

    // How the sampled SDA level is chosen on each tick
    typedef enum int {
        LINE_HIGH,
        LINE_LOW,
        LINE_RANDOM
    } line_mode_t;

    // Line sequencer predictor plus the store of expected pin results
    class line_tracker;
        logic [DELAY_W-1:0]   tick_delay;
        logic [BYTE_W-1:0]    poll_limit;
        op_t                  op;
        phase_t               ph;
        logic [BIT_CNT_W-1:0] bit_idx;
        logic [BYTE_W-1:0]    shifter;
        logic [DELAY_W-1:0]   delay_cnt;
        logic [BYTE_W-1:0]    poll_cnt;
        logic [BYTE_W-1:0]    last_read;
        logic [BYTE_W-1:0]    last_ack;
        logic                 scl_lvl;
        logic                 scl_en;
        logic                 sda_lvl;
        logic                 sda_en;
        result_t              pending_lines[$];
        int                   errors;
        int                   checked;
        int                   done_cnt;
        int                   acked;
        int                   unacked;
        int                   cmd_cnt[8];

        function new();
            tick_delay = DELAY_RESET;
            poll_limit = POLL_LIMIT_RESET;
            op         = OP_IDLE;
            ph         = PH_IDLE;
            bit_idx    = '0;
            shifter    = '0;
            delay_cnt  = '0;
            poll_cnt   = '0;
            last_read  = '0;
            last_ack   = '0;
            scl_lvl    = 1'b1;
            scl_en     = 1'b0;
            sda_lvl    = 1'b1;
            sda_en     = 1'b0;
            errors     = 0;
            checked    = 0;
            done_cnt   = 0;
            acked      = 0;
            unacked    = 0;
            foreach (cmd_cnt[i]) cmd_cnt[i] = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DELAY_W-1:0] val);
            if (idx == REG_DELAY_CYCLES)
                tick_delay = val;
            else
                poll_limit = val[BYTE_W-1:0];
        endfunction

        function bit busy();
            return op != OP_IDLE;
        endfunction

        // Next accepted tick raises done
        function bit finish_next();
            return op != OP_IDLE && delay_cnt == '0 && ph == PH_FINISH;
        endfunction

        function int pending();
            return pending_lines.size();
        endfunction

        // Zero delay behaves as one tick
        function void hold(phase_t nxt);
            logic [DELAY_W-1:0] d;
            d = (tick_delay == '0) ? DELAY_W'(1) : tick_delay;
            delay_cnt = d - 1'b1;
            ph = nxt;
        endfunction

        function void launch(op_t cmd, logic [BYTE_W-1:0] wbyte);
            op = cmd;
            bit_idx = '0;
            cmd_cnt[cmd]++;
            case (cmd)
                OP_START:
                begin
                    scl_lvl = 1'b1;
                    sda_lvl = 1'b1;
                    sda_en  = 1'b1;
                    scl_en  = 1'b1;
                    hold(PH_S_SDA_LOW);
                end
                OP_STOP:
                begin
                    sda_en  = 1'b1;
                    sda_lvl = 1'b0;
                    hold(PH_T_SCL_HIGH);
                end
                OP_WRITE:
                begin
                    shifter = wbyte;
                    sda_en  = 1'b1;
                    sda_lvl = shifter[7];
                    hold(PH_W_SCL_HIGH);
                end
                default:
                begin
                    shifter = '0;
                    sda_en  = 1'b0;
                    sda_lvl = 1'b1;
                    hold(PH_R_SCL_HIGH);
                end
            endcase
        endfunction

        // One line step; returns 1 on the finish tick
        function bit advance(logic nk, logic sda);
            case (ph)
                PH_S_SDA_LOW:
                begin
                    sda_lvl = 1'b0;
                    hold(PH_S_SCL_LOW);
                end
                PH_S_SCL_LOW, PH_W_SCL_END:
                begin
                    scl_lvl = 1'b0;
                    hold(PH_FINISH);
                end
                PH_T_SCL_HIGH:
                begin
                    scl_lvl = 1'b1;
                    hold(PH_T_SDA_HIGH);
                end
                PH_T_SDA_HIGH:
                begin
                    sda_lvl = 1'b1;
                    hold(PH_FINISH);
                end
                PH_W_SCL_HIGH:
                begin
                    scl_lvl = 1'b1;
                    hold(PH_W_SCL_LOW);
                end
                PH_W_SCL_LOW:
                begin
                    scl_lvl = 1'b0;
                    shifter = shifter << 1;
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx < BITS_PER_BYTE)
                    begin
                        sda_en  = 1'b1;
                        sda_lvl = shifter[7];
                        hold(PH_W_SCL_HIGH);
                    end
                    else
                    begin
                        sda_en  = 1'b0;
                        sda_lvl = 1'b1;
                        hold(PH_W_ACK_SCL_HIGH);
                    end
                end
                PH_W_ACK_SCL_HIGH:
                begin
                    scl_lvl  = 1'b1;
                    poll_cnt = (poll_limit == '0) ? BYTE_W'(1) : poll_limit;
                    hold(PH_W_POLL);
                end
                PH_W_POLL:
                begin
                    if (!sda)
                    begin
                        // acknowledge seen: keep the remaining count, drop SCL now
                        last_ack = poll_cnt;
                        scl_lvl  = 1'b0;
                        acked++;
                        hold(PH_FINISH);
                    end
                    else
                    begin
                        poll_cnt = poll_cnt - 1'b1;
                        if (poll_cnt == '0)
                        begin
                            last_ack = '0;
                            unacked++;
                            hold(PH_W_SCL_END);
                        end
                        else
                            hold(PH_W_POLL);
                    end
                end
                PH_R_SCL_HIGH:
                begin
                    scl_lvl = 1'b1;
                    hold(PH_R_SAMPLE);
                end
                PH_R_SAMPLE:
                begin
                    shifter = {shifter[BYTE_W-2:0], sda};
                    scl_lvl = 1'b0;
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx < BITS_PER_BYTE)
                        hold(PH_R_SCL_HIGH);
                    else
                    begin
                        last_read = shifter;
                        hold(PH_R_ACK_DRIVE);
                    end
                end
                PH_R_ACK_DRIVE:
                begin
                    sda_en  = 1'b1;
                    sda_lvl = nk;
                    hold(PH_R_ACK_HIGH);
                end
                PH_R_ACK_HIGH:
                begin
                    scl_lvl = 1'b1;
                    hold(PH_R_ACK_LOW);
                end
                PH_R_ACK_LOW:
                begin
                    scl_lvl = 1'b0;
                    hold(PH_R_SDA_LOW);
                end
                PH_R_SDA_LOW:
                begin
                    sda_lvl = 1'b0;
                    hold(PH_FINISH);
                end
                default:
                begin
                    op = OP_IDLE;
                    ph = PH_IDLE;
                    delay_cnt = '0;
                    return 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        // Accepted input transaction: advance one tick, queue the expected result
        function void take_tick(logic [IN_TDATA_W-1:0] td);
            logic [2:0] cmd;
            logic       done;
            result_t    r;
            cmd  = td[2:0];
            done = 1'b0;
            if (op == OP_IDLE)
            begin
                // reserved codes and OP_IDLE are ignored
                if (cmd >= OP_START && cmd <= OP_READ)
                    launch(op_t'(cmd), td[10:3]);
            end
            else if (delay_cnt != '0)
                delay_cnt = delay_cnt - 1'b1;
            else
                done = advance(td[11], td[12]);
            r.scl_level  = scl_lvl;
            r.scl_enable = scl_en;
            r.sda_level  = sda_lvl;
            r.sda_enable = sda_en;
            r.busy_res   = (op != OP_IDLE);
            r.done_res   = done;
            r.read_byte  = last_read;
            r.ack_count  = last_ack;
            pending_lines.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // Accepted output transaction: compare with the oldest expectation
        function void check_pins(logic [OUT_TDATA_W-1:0] td);
            result_t got;
            result_t want;
            got = td[$bits(result_t)-1:0];
            if (pending_lines.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, td);
                return;
            end
            want = pending_lines.pop_front();
            checked++;
            if (want.done_res)
                done_cnt++;
            compare_field("scl_level", 32'(want.scl_level), 32'(got.scl_level));
            compare_field("scl_enable", 32'(want.scl_enable), 32'(got.scl_enable));
            compare_field("sda_level", 32'(want.sda_level), 32'(got.sda_level));
            compare_field("sda_enable", 32'(want.sda_enable), 32'(got.sda_enable));
            compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
            compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
            compare_field("ack_count", 32'(want.ack_count), 32'(got.ack_count));
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    reg_idx_t               cfg_index = REG_DELAY_CYCLES;
    logic [DELAY_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    line_tracker tracker = new();

    bit tx_dense   = 1'b0;
    bit rx_free    = 1'b0;
    int burst_left = 0;
    int zero_odds  = 8;
    int ticks_sent = 0;
    int reg_writes = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    op_t frame_q[$];

    i2c_master_byte_engine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver backpressure: modes are chosen at random; always ready when rx_free is set
    always @(posedge clk)
    begin
        if (rx_free)
            m_tready <= 1'b1;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(16, 96);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_left[2:0] == 3'd0);
            endcase
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_pins(m_tdata);
    end

    function logic line_bit(line_mode_t mode);
        case (mode)
            LINE_HIGH: return 1'b1;
            LINE_LOW:  return 1'b0;
            default:   return ($urandom_range(0, 15) < zero_odds) ? 1'b0 : 1'b1;
        endcase
    endfunction

    // Send one tick; senders work in bursts separated by short gaps unless tx_dense is set
    task automatic send_tick(logic [2:0] cmd, logic [7:0] wbyte, logic nk, logic sda);
        if (!tx_dense && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sda, nk, wbyte, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.take_tick(s_tdata);
        ticks_sent++;
    endtask

    // Issue a command, then tick until the sequence has finished
    task automatic run_cmd(logic [2:0] cmd, logic [7:0] wbyte, logic nk,
                           line_mode_t mode, logic [2:0] noise);
        send_tick(cmd, wbyte, nk, line_bit(mode));
        while (tracker.busy())
            send_tick(noise, 8'($urandom_range(0, 255)), nk, line_bit(mode));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only with the sequencer idle and all results back
    task automatic apply_reg(reg_idx_t idx, logic [DELAY_W-1:0] val);
        while (tracker.busy())
            send_tick(OP_IDLE, 8'h00, 1'b0, 1'b1);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, val);
        reg_writes++;
    endtask

    // Random ticks: mostly start / data / stop frames, some stray codes
    task automatic random_phase(int n_ticks);
        int         ticks;
        logic [2:0] cmd;
        ticks = 0;
        while (ticks < n_ticks || tracker.busy())
        begin
            if (!tracker.busy())
            begin
                case ($urandom_range(0, 7))
                    0:       zero_odds = 0;
                    1, 2:    zero_odds = 1;
                    3, 4:    zero_odds = 3;
                    default: zero_odds = 8;
                endcase
                if ($urandom_range(0, 9) == 0)
                    cmd = 3'($urandom_range(0, 7));
                else
                begin
                    if (frame_q.size() == 0)
                    begin
                        frame_q.push_back(OP_START);
                        repeat ($urandom_range(1, 3))
                            frame_q.push_back($urandom_range(0, 1) ? OP_WRITE : OP_READ);
                        frame_q.push_back(OP_STOP);
                    end
                    cmd = frame_q.pop_front();
                end
            end
            else if (tracker.finish_next() && $urandom_range(0, 1))
                cmd = 3'($urandom_range(OP_START, OP_READ));
            else
                cmd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_IDLE;
            send_tick(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      line_bit(LINE_RANDOM));
            ticks++;
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("i2c_master_byte_engine_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset poll limit: full count with no acknowledge, then a random late one
        apply_reg(REG_DELAY_CYCLES, 16'd1);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, LINE_HIGH, OP_IDLE);
        zero_odds = 1;
        run_cmd(OP_WRITE, 8'h5A, 1'b0, LINE_RANDOM, OP_STOP);

        // Directed: zero register values
        apply_reg(REG_DELAY_CYCLES, 16'd0);
        apply_reg(REG_ACK_POLL_LIMIT, 16'd0);
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
            send_tick(3'(c), 8'hFF, 1'b1, 1'b0);
        send_tick(OP_IDLE, 8'hFF, 1'b1, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, LINE_HIGH, OP_IDLE);
        // commands while busy and on the finish tick must be dropped
        run_cmd(OP_WRITE, 8'h00, 1'b1, LINE_LOW, OP_READ);
        run_cmd(OP_READ, 8'h00, 1'b1, LINE_HIGH, OP_IDLE);
        run_cmd(OP_READ, 8'hFF, 1'b0, LINE_LOW, OP_START);
        run_cmd(OP_STOP, 8'h00, 1'b0, LINE_HIGH, OP_WRITE);

        apply_reg(REG_DELAY_CYCLES, 16'd2);
        apply_reg(REG_ACK_POLL_LIMIT, 16'd2);
        zero_odds = 8;
        run_cmd(OP_START, 8'h00, 1'b0, LINE_RANDOM, OP_IDLE);
        run_cmd(OP_WRITE, 8'h80, 1'b0, LINE_RANDOM, OP_IDLE);
        run_cmd(OP_WRITE, 8'h01, 1'b0, LINE_RANDOM, OP_IDLE);
        run_cmd(OP_READ, 8'h00, 1'b1, LINE_RANDOM, OP_IDLE);
        run_cmd(OP_STOP, 8'h00, 1'b0, LINE_RANDOM, OP_IDLE);

        // Random frames over several register settings
        apply_reg(REG_DELAY_CYCLES, 16'd1);
        apply_reg(REG_ACK_POLL_LIMIT, 16'd1);
        random_phase(70);
        apply_reg(REG_DELAY_CYCLES, 16'd2);
        apply_reg(REG_ACK_POLL_LIMIT, DELAY_W'($urandom_range(2, 8)));
        random_phase(70);
        apply_reg(REG_DELAY_CYCLES, DELAY_W'($urandom_range(1, 3)));
        apply_reg(REG_ACK_POLL_LIMIT, DELAY_W'($urandom_range(1, 12)));
        random_phase(70);

        // Full rate: no sender gaps and no receiver stalls
        apply_reg(REG_DELAY_CYCLES, 16'd1);
        tx_dense = 1'b1;
        rx_free  = 1'b1;
        random_phase(24);

        drain();
        $display("Run covered %0d ticks, %0d results checked, %0d register writes.",
                 ticks_sent, tracker.checked, reg_writes);
        $display("Commands: %0d start, %0d stop, %0d write (%0d acked, %0d not), %0d read.",
                 tracker.cmd_cnt[OP_START], tracker.cmd_cnt[OP_STOP],
                 tracker.cmd_cnt[OP_WRITE], tracker.acked, tracker.unacked,
                 tracker.cmd_cnt[OP_READ]);
        if (tracker.errors == 0)
            $display("i2c_master_byte_engine_core_tb: PASS");
        else
            $display("i2c_master_byte_engine_core_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2c_master_byte_engine_core.sv
test/i2c_master_byte_engine_core_tb.sv
